[rtl/binary_box_dilation_defines.svh]
// ----------------------------------------------------------------------------
// Binary box dilation assertion macros
// Shared concurrent assertion forms used by the block's RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_BOX_DILATION_DEFINES_SVH
`define BINARY_BOX_DILATION_DEFINES_SVH

// Condition must hold on every rising clock edge outside reset.
`define BBD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BBD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/bbd_pkg.sv]
// ----------------------------------------------------------------------------
// bbd_pkg
// Types and constants shared by the binary box dilation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

  // Width of coordinate arithmetic: holds x + window and any size up to 256.
  localparam int CW = 9;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } bbd_cmd_t;

  typedef enum logic [1:0] {
    REG_GLYPH_WIDTH  = 2'd0,
    REG_GLYPH_HEIGHT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2
  } bbd_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_MOD,
    S_RD_SETUP,
    S_RD_RUN,
    S_RD_LAST,
    S_RESULT
  } bbd_state_t;

  typedef struct packed {
    logic [6:0] glyph_width;
    logic [6:0] glyph_height;
    logic [3:0] window_size;
  } bbd_cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } bbd_mem_ctl_t;

endpackage

`default_nettype wire

[rtl/binary_box_dilation.sv]
// ----------------------------------------------------------------------------
// binary_box_dilation
// One-bit glyph bitmap with pixel writes and square-window dilated reads.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per pixel command. in_tuser is the command
//           (0 write, 1 read); in_tdata carries x, y and the pixel bit.
//   out_* : one transaction per read command carrying the dilated bit;
//           write commands produce nothing.
//   cfg_* : APB-style registers at 0x0 glyph_width, 0x4 glyph_height,
//           0x8 window_size. Write them only while the block is idle.
// Sequencing:
//   A write is a read-modify-write of one column word; a write whose
//   address lies outside storage is dropped. A read issues one memory read
//   per clipped window column (n <= window_size) in S_RD_RUN, after
//   S_RD_SETUP and before S_RD_LAST and S_RESULT, which loads out_tvalid;
//   an empty window goes from S_RD_SETUP straight to S_RESULT. The block
//   then returns to idle for the next item. One item is in flight at a time.
// Reset clears the bitmap at once through per-column valid bits and returns
// the registers to 64, 64 and 2. A stalled receiver holds the result in the
// output register; the block takes the next item meanwhile and waits only if
// another read result is ready before the first one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_box_dilation import bbd_pkg::*; #(
  parameter int MAX_X      = 64,
  parameter int MAX_Y      = 64,
  parameter int MAX_WINDOW = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [5:0] x_pos, [11:6] y_pos, [12] pixel_value
  input  wire logic        in_tuser,   // [0] command
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // [0] dilated_bit
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int ADDR_W = (MAX_X > 1) ? $clog2(MAX_X) : 1;

  bbd_cfg_t         cfg_r, cfg_nxt;
  bbd_reg_t         reg_idx;
  logic             cfg_wr;

  bbd_mem_ctl_t     mem_ctl;
  logic [ADDR_W-1:0] mem_rd_addr, mem_wr_addr;
  logic [MAX_Y-1:0]  mem_rd_data, mem_wr_data;
  logic              out_bit;

  // ---------------- configuration registers ----------------
  assign cfg_pready = 1'b1;
  assign reg_idx    = bbd_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_GLYPH_WIDTH:  cfg_nxt.glyph_width  = cfg_pwdata[6:0];
        REG_GLYPH_HEIGHT: cfg_nxt.glyph_height = cfg_pwdata[6:0];
        REG_WINDOW_SIZE:  cfg_nxt.window_size  = cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GLYPH_WIDTH:  cfg_prdata = 32'(cfg_r.glyph_width);
      REG_GLYPH_HEIGHT: cfg_prdata = 32'(cfg_r.glyph_height);
      REG_WINDOW_SIZE:  cfg_prdata = 32'(cfg_r.window_size);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width  <= 7'd64;
      cfg_r.glyph_height <= 7'd64;
      cfg_r.window_size  <= 4'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- sequencer ----------------
  bbd_ctrl #(
    .MAX_X      (MAX_X),
    .MAX_Y      (MAX_Y),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_cmd      (in_tuser),
    .in_x        (in_tdata[5:0]),
    .in_y        (in_tdata[11:6]),
    .in_pix      (in_tdata[12]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_bit     (out_bit),
    .mem_ctl     (mem_ctl),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // ---------------- glyph store ----------------
  bbd_glyph_mem #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign out_tdata = {7'd0, out_bit};

endmodule

`default_nettype wire

[rtl/bbd_glyph_mem.sv]
// ----------------------------------------------------------------------------
// bbd_glyph_mem
// Column-word glyph store, one synchronous read and one write port, with a
// per-column valid bit so that reset clears the bitmap at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_glyph_mem import bbd_pkg::*; #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  localparam int ADDR_W = (MAX_X > 1) ? $clog2(MAX_X) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bbd_mem_ctl_t      ctl,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [MAX_Y-1:0]  rd_data,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [MAX_Y-1:0]  wr_data
);

  logic [MAX_Y-1:0] glyph_mem [MAX_X];
  logic [MAX_X-1:0] valid_r;
  logic [MAX_Y-1:0] rd_word_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      glyph_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_word_r <= glyph_mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // never-written column reads as cleared
  assign rd_data = rd_vld_r ? rd_word_r : '0;

endmodule

`default_nettype wire

[rtl/bbd_ctrl.sv]
// ----------------------------------------------------------------------------
// bbd_ctrl
// Sequencer: pixel writes as read-modify-write, dilated reads as one
// column read per window column, masked and ORed, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_box_dilation_defines.svh"

module bbd_ctrl import bbd_pkg::*; #(
  parameter int MAX_X      = 64,
  parameter int MAX_Y      = 64,
  parameter int MAX_WINDOW = 8,
  localparam int ADDR_W = (MAX_X > 1) ? $clog2(MAX_X) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bbd_cfg_t          cfg,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_cmd,
  input  wire logic [5:0]        in_x,
  input  wire logic [5:0]        in_y,
  input  wire logic              in_pix,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic                   out_bit,
  output bbd_mem_ctl_t           mem_ctl,
  output logic      [ADDR_W-1:0] mem_rd_addr,
  input  wire logic [MAX_Y-1:0]  mem_rd_data,
  output logic      [ADDR_W-1:0] mem_wr_addr,
  output logic      [MAX_Y-1:0]  mem_wr_data
);

  bbd_state_t       state_r, state_nxt;
  logic [5:0]       x_r, x_nxt;
  logic [5:0]       y_r, y_nxt;
  logic             pix_r, pix_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    xe_r, xe_nxt;
  logic [MAX_Y-1:0] mask_r, mask_nxt;
  logic             acc_r, acc_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_bit_r, out_bit_nxt;

  // clipped window geometry, used in S_RD_SETUP
  logic [CW-1:0] w_sat, h_sat, win_sat, xsum, ysum, ye, nrows;
  logic          rd_ok, wr_ok, out_free;

  always_comb begin
    w_sat   = (CW'(cfg.glyph_width) > CW'(MAX_X)) ? CW'(MAX_X) : CW'(cfg.glyph_width);
    h_sat   = (CW'(cfg.glyph_height) > CW'(MAX_Y)) ? CW'(MAX_Y) : CW'(cfg.glyph_height);
    win_sat = (CW'(cfg.window_size) > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW)
                                                       : CW'(cfg.window_size);
    xsum    = CW'(x_r) + win_sat;
    ysum    = CW'(y_r) + win_sat;
    ye      = (ysum > h_sat) ? h_sat : ysum;
    nrows   = ye - CW'(y_r);
    rd_ok   = (CW'(x_r) < w_sat) && (CW'(y_r) < h_sat) && (win_sat != '0);
    wr_ok   = (CW'(in_x) < CW'(MAX_X)) && (CW'(in_y) < CW'(MAX_Y));
    out_free = !out_valid_r || out_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (bbd_cmd_t'(in_cmd) == CMD_READ) begin
            state_nxt = S_RD_SETUP;
          end else if (wr_ok) begin
            state_nxt = S_WR_MOD;
          end
        end
      end
      S_WR_MOD:   state_nxt = S_IDLE;
      S_RD_SETUP: state_nxt = rd_ok ? S_RD_RUN : S_RESULT;
      S_RD_RUN: begin
        if (col_r + CW'(1) == xe_r) begin
          state_nxt = S_RD_LAST;
        end
      end
      S_RD_LAST:  state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready     = 1'b0;
    mem_ctl       = '0;
    mem_rd_addr   = col_r[ADDR_W-1:0];
    mem_wr_addr   = ADDR_W'(x_r);
    mem_wr_data   = mem_rd_data;
    x_nxt         = x_r;
    y_nxt         = y_r;
    pix_nxt       = pix_r;
    col_nxt       = col_r;
    xe_nxt        = xe_r;
    mask_nxt      = mask_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;

    if (pend_r) begin
      acc_nxt = acc_r | (|(mem_rd_data & mask_r));
    end

    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        mem_rd_addr = ADDR_W'(in_x);
        if (in_tvalid) begin
          x_nxt   = in_x;
          y_nxt   = in_y;
          pix_nxt = in_pix;
          if (bbd_cmd_t'(in_cmd) == CMD_WRITE && wr_ok) begin
            mem_ctl.rd_en = 1'b1;
          end
        end
      end
      S_WR_MOD: begin
        mem_ctl.wr_en = 1'b1;
        if (pix_r) begin
          mem_wr_data = mem_rd_data | (MAX_Y'(1) << y_r);
        end else begin
          mem_wr_data = mem_rd_data & ~(MAX_Y'(1) << y_r);
        end
      end
      S_RD_SETUP: begin
        col_nxt  = CW'(x_r);
        xe_nxt   = (xsum > w_sat) ? w_sat : xsum;
        mask_nxt = ~({MAX_Y{1'b1}} << nrows) << y_r;
        acc_nxt  = 1'b0;
      end
      S_RD_RUN: begin
        mem_ctl.rd_en = 1'b1;
        col_nxt       = col_r + CW'(1);
        pend_nxt      = 1'b1;
      end
      S_RD_LAST: begin
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = acc_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    pix_r     <= pix_nxt;
    col_r     <= col_nxt;
    xe_r      <= xe_nxt;
    mask_r    <= mask_nxt;
    acc_r     <= acc_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_bit    = out_bit_r;

  `BBD_ASSERT_ALWAYS(a_no_rw_overlap, clk, rst_n, !(mem_ctl.rd_en && mem_ctl.wr_en), "read and write in one cycle")
  `BBD_ASSERT_IMPLIES(a_wr_after_rd, clk, rst_n, mem_ctl.wr_en, $past(mem_ctl.rd_en), "write-back without prior read")
  `BBD_ASSERT_IMPLIES(a_pend_tracks_rd, clk, rst_n, pend_r, $past(mem_ctl.rd_en), "accumulate without read")
  `BBD_ASSERT_IMPLIES(a_col_in_window, clk, rst_n, state_r == S_RD_RUN, col_r < xe_r, "column past window end")

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Binary box dilation testbench
// Drives pixel write/read transactions into the block and checks every
// dilated bit against a typed value or a behavioral predictor of the glyph
// bitmap. APB-style register writes are read back, but for the spare slot.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import bbd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Sizes as built into the block under test.
  localparam int GLYPH_MAX_X   = 64;
  localparam int GLYPH_MAX_Y   = 64;
  localparam int GLYPH_MAX_WIN = 8;

  // Run watchdog, in clock cycles.
  localparam int CYCLE_LIMIT = 500000;
  // Cycles allowed for an item with no result to finish before a register write.
  localparam int SETTLE_CYCLES = 16;

  // Address of the one slot past the last register; writes there do nothing.
  localparam logic [3:0] REG_ADDR_SPARE = 4'hC;

  // Directed table: a row is either a pixel transaction or a register write.
  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;
  localparam logic CHK  = 1'b1;  // expected bit typed into the row
  localparam logic PRED = 1'b0;  // expected bit comes from the predictor

  typedef struct {
    row_kind_t   kind;
    bbd_cmd_t    cmd;
    logic [5:0]  x;
    logic [5:0]  y;
    logic        pix;
    logic        typed;
    logic        dil;
    logic [3:0]  addr;
    logic [31:0] val;
  } row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports
  // --------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;    // [5:0] x_pos, [11:6] y_pos, [12] pixel_value
  logic        in_tuser    = 1'b0;  // [0] command
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;           // [0] dilated_bit
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always #1 clk = ~clk;

  binary_box_dilation u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state: shadow bitmap (word x = column x, bit y = pixel (x, y))
  // and shadow registers, at their reset values.
  // --------------------------------------------------------------------------
  logic [GLYPH_MAX_Y-1:0] glyph_cols [GLYPH_MAX_X];
  logic [6:0]             gw   = 7'd64;
  logic [6:0]             gh   = 7'd64;
  logic [3:0]             gwin = 4'd2;

  logic dilated_q [$];   // dilated bits still owed by the block, oldest first
  int   mismatches = 0;
  bit   gaps_on    = 1'b1;
  int   stall_left = 0;
  int   cycle_cnt  = 0;
  logic exp_bit;

  initial foreach (glyph_cols[i]) glyph_cols[i] = '0;

  // OR of the source pixels in the window anchored at (x, y), clipped to the
  // glyph. Sizes saturate; a zero size or window gives 0.
  function automatic logic dilate_px(logic [5:0] x, logic [5:0] y);
    int w, h, win, xe, ye;
    logic hit;
    w   = (gw > GLYPH_MAX_X) ? GLYPH_MAX_X : int'(gw);
    h   = (gh > GLYPH_MAX_Y) ? GLYPH_MAX_Y : int'(gh);
    win = (gwin > GLYPH_MAX_WIN) ? GLYPH_MAX_WIN : int'(gwin);
    hit = 1'b0;
    if (int'(x) >= w || int'(y) >= h || win == 0) return 1'b0;
    xe = (int'(x) + win > w) ? w : int'(x) + win;
    ye = (int'(y) + win > h) ? h : int'(y) + win;
    for (int a = int'(x); a < xe; a++)
      for (int b = int'(y); b < ye; b++)
        hit |= glyph_cols[a][b];
    return hit;
  endfunction

  function automatic logic [3:0] reg_addr(bbd_reg_t r);
    return {r, 2'b00};
  endfunction

  function automatic row_t px_row(bbd_cmd_t c, int x, int y, logic p, logic typed,
                                  logic dil);
    row_t r;
    r.kind  = ROW_PIXEL;
    r.cmd   = c;
    r.x     = x[5:0];
    r.y     = y[5:0];
    r.pix   = p;
    r.typed = typed;
    r.dil   = dil;
    r.addr  = '0;
    r.val   = '0;
    return r;
  endfunction

  function automatic row_t reg_row(logic [3:0] a, logic [31:0] v);
    row_t r;
    r.kind  = ROW_REG;
    r.cmd   = CMD_WRITE;
    r.x     = '0;
    r.y     = '0;
    r.pix   = 1'b0;
    r.typed = 1'b0;
    r.dil   = 1'b0;
    r.addr  = a;
    r.val   = v;
    return r;
  endfunction

  // Coordinate mix: mostly inside the phase's working box so reads land on
  // written pixels, some straddling the clip edge, some anywhere.
  function automatic logic [5:0] pick_coord(int lim, int base, int span);
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 2)      v = $urandom_range(0, 63);
    else if (r < 4) v = lim - 3 + $urandom_range(0, 3);
    else            v = base + $urandom_range(0, span - 1);
    if (v < 0)  v = 0;
    if (v > 63) v = 63;
    return v[5:0];
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Valid stays high across back-to-back transactions; it only
  // drops for an idle burst or a drain.
  // --------------------------------------------------------------------------
  task automatic push_pixel_cmd(bbd_cmd_t c, logic [5:0] x, logic [5:0] y, logic p,
                                logic typed, logic dil);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {3'b000, p, y, x};
    do @(posedge clk); while (!in_tready);
    // Transaction accepted at this edge: advance the shadow bitmap.
    if (c == CMD_WRITE) glyph_cols[x][y] = p;
    else                dilated_q.push_back(typed ? dil : dilate_px(x, y));
  endtask

  // Hold off input until every owed result has arrived, then give a trailing
  // write time to land before anything else touches the block.
  task automatic wait_block_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (dilated_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_xfer(logic wr, logic [3:0] a, logic [31:0] d, output logic [31:0] rd);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= a;
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Register write plus read-back; the spare slot is written but not read.
  task automatic set_reg(logic [3:0] a, logic [31:0] d);
    logic [31:0] rb, want;
    logic        known;
    apb_xfer(1'b1, a, d, rb);
    known = 1'b1;
    want  = '0;
    case (a[3:2])
      REG_GLYPH_WIDTH:  begin gw   = d[6:0]; want = {25'd0, gw};   end
      REG_GLYPH_HEIGHT: begin gh   = d[6:0]; want = {25'd0, gh};   end
      REG_WINDOW_SIZE:  begin gwin = d[3:0]; want = {28'd0, gwin}; end
      default:          known = 1'b0;
    endcase
    if (known) begin
      apb_xfer(1'b0, a, '0, rb);
      if (rb !== want) begin
        $display("%0t: register 0x%0h read back, expected 0x%0h, got 0x%0h",
                 $realtime, a, want, rb);
        mismatches++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each transaction, then pick next cycle's ready.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (dilated_q.size() == 0) begin
        $display("%0t: result with none pending, expected none, got 0x%0h",
                 $realtime, out_tdata);
        mismatches++;
      end else begin
        exp_bit = dilated_q.pop_front();
        if (out_tdata !== {7'd0, exp_bit}) begin
          $display("%0t: dilated_bit mismatch, expected 0x%0h, got 0x%0h",
                   $realtime, {7'd0, exp_bit}, out_tdata);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  row_t dir_rows [$];

  initial begin
    int          w_eff, h_eff, span, bx, by, dens;
    bbd_cmd_t    c;
    logic [5:0]  x, y;
    logic        p;
    logic [31:0] wv, hv, sv;

    // Directed: bitmap starts cleared at 64 x 64, window 2.
    dir_rows = '{
      px_row(CMD_READ,   0,  0, 1'b1, CHK,  1'b0),   // cleared by reset
      px_row(CMD_READ,  63, 63, 1'b0, CHK,  1'b0),
      px_row(CMD_WRITE,  0,  0, 1'b1, PRED, 1'b0),
      px_row(CMD_READ,   0,  0, 1'b0, CHK,  1'b1),
      px_row(CMD_WRITE, 63, 63, 1'b1, PRED, 1'b0),   // far corner
      px_row(CMD_READ,  62, 62, 1'b1, CHK,  1'b1),   // window reaches corner
      px_row(CMD_READ,  63, 63, 1'b0, CHK,  1'b1),   // window clipped at edge
      px_row(CMD_READ,  61, 61, 1'b0, PRED, 1'b0),
      px_row(CMD_WRITE, 63,  0, 1'b1, PRED, 1'b0),
      px_row(CMD_READ,  62,  0, 1'b1, PRED, 1'b0),
      reg_row(reg_addr(REG_WINDOW_SIZE), 32'd0),
      px_row(CMD_READ,   0,  0, 1'b1, CHK,  1'b0),   // window zero
      reg_row(reg_addr(REG_WINDOW_SIZE), 32'hFFFF_FFFF), // window saturates
      px_row(CMD_READ,  56, 56, 1'b0, PRED, 1'b0),
      px_row(CMD_READ,  55, 55, 1'b0, PRED, 1'b0),
      reg_row(reg_addr(REG_GLYPH_WIDTH), 32'd0),
      px_row(CMD_READ,   0,  0, 1'b0, CHK,  1'b0),   // zero width
      reg_row(reg_addr(REG_GLYPH_WIDTH), 32'hFFFF_FFFF), // width saturates
      px_row(CMD_READ,  63, 63, 1'b1, PRED, 1'b0),
      reg_row(reg_addr(REG_GLYPH_HEIGHT), 32'd1),
      px_row(CMD_READ,   0,  1, 1'b0, CHK,  1'b0),   // outside glyph in y
      px_row(CMD_READ,  62,  0, 1'b0, PRED, 1'b0),
      reg_row(reg_addr(REG_GLYPH_HEIGHT), 32'd64),
      reg_row(reg_addr(REG_GLYPH_WIDTH), 32'd1),
      px_row(CMD_READ,   1,  0, 1'b1, CHK,  1'b0),   // outside glyph in x
      px_row(CMD_WRITE, 63, 63, 1'b0, PRED, 1'b0),
      px_row(CMD_WRITE, 40, 50, 1'b1, PRED, 1'b0),   // stored beyond glyph size
      reg_row(reg_addr(REG_GLYPH_WIDTH), 32'd64),
      reg_row(reg_addr(REG_WINDOW_SIZE), 32'd1),
      px_row(CMD_READ,  40, 50, 1'b0, CHK,  1'b1),
      px_row(CMD_READ,  39, 49, 1'b1, PRED, 1'b0),
      reg_row(REG_ADDR_SPARE, 32'hFFFF_FFFF),         // no register here
      px_row(CMD_READ,  40, 50, 1'b0, PRED, 1'b0),
      reg_row(reg_addr(REG_WINDOW_SIZE), 32'd2)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_block_idle();
        set_reg(dir_rows[i].addr, dir_rows[i].val);
      end else begin
        push_pixel_cmd(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].pix,
                       dir_rows[i].typed, dir_rows[i].dil);
      end
    end

    // Random phases: each one reprograms the glyph, then mixes writes and
    // reads around a small working box. The last phase has no gaps or stalls.
    for (int ph = 0; ph < 11; ph++) begin
      gaps_on = (ph < 10);
      wait_block_idle();

      case ($urandom_range(0, 5))
        0:       wv = 32'd1;
        1:       wv = 32'd64;
        2:       wv = 32'd127;
        3:       wv = $urandom();               // any register value, upper bits junk
        default: wv = $urandom_range(2, 63);
      endcase
      case ($urandom_range(0, 5))
        0:       hv = 32'd1;
        1:       hv = 32'd64;
        2:       hv = 32'd127;
        3:       hv = $urandom();
        default: hv = $urandom_range(2, 63);
      endcase
      case ($urandom_range(0, 7))
        0:       sv = 32'd0;
        1:       sv = 32'd15;
        2:       sv = 32'd8;
        default: sv = $urandom_range(1, 7);
      endcase
      // Make sure the extremes show up regardless of the draw.
      if (ph == 0) begin wv = 32'd127; hv = 32'd64;  sv = 32'd8;  end
      if (ph == 1) begin wv = 32'd64;  hv = 32'd1;   sv = 32'd15; end
      if (ph == 2) begin wv = 32'd1;   hv = 32'd127; sv = 32'd1;  end

      set_reg(reg_addr(REG_GLYPH_WIDTH), wv);
      set_reg(reg_addr(REG_GLYPH_HEIGHT), hv);
      set_reg(reg_addr(REG_WINDOW_SIZE), sv);

      w_eff = (gw > GLYPH_MAX_X) ? GLYPH_MAX_X : int'(gw);
      h_eff = (gh > GLYPH_MAX_Y) ? GLYPH_MAX_Y : int'(gh);
      span  = $urandom_range(2, 16);
      bx    = $urandom_range(0, (w_eff > span) ? w_eff - span : 0);
      by    = $urandom_range(0, (h_eff > span) ? h_eff - span : 0);
      dens  = $urandom_range(0, 60);   // percent of writes that set a pixel

      for (int i = 0; i < 120; i++) begin
        c = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
        x = pick_coord(w_eff, bx, span);
        y = pick_coord(h_eff, by, span);
        p = (c == CMD_WRITE) ? ($urandom_range(0, 99) < dens) : 1'($urandom_range(0, 1));
        push_pixel_cmd(c, x, y, p, PRED, 1'b0);
        // Occasionally starve the block until it has caught up completely.
        if (i == 60 && ph % 3 == 1) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (dilated_q.size() != 0);
        end
      end
    end

    // Drain and let a trailing write settle.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (dilated_q.size() != 0);
    repeat (24) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
